/* rtl/core/ila_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ila_pkg
// Shared types, widths and constants of the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam int unsigned HEAP_BYTES  = 65536;
  localparam int unsigned ADDR_W      = $clog2(HEAP_BYTES);
  localparam int unsigned WIDX_W      = ADDR_W - 2;
  localparam int unsigned WORD_DEPTH  = HEAP_BYTES / 4;
  localparam int unsigned DATA_W      = ADDR_W + 1;
  localparam int unsigned PTR_W       = ADDR_W + 2;
  localparam int unsigned EXT_W       = (PTR_W > 18) ? PTR_W + 1 : 19;

  localparam int unsigned REQ_W       = 16;
  localparam int unsigned BADDR_W     = 16;
  localparam int unsigned CHUNK_W     = 17;

  localparam int unsigned CHUNK_RESET = 256;
  localparam int unsigned MIN_BLOCK   = 16;
  localparam int unsigned FIRST_BP    = 8;
  localparam int unsigned FIRST_BLOCK = 16;
  localparam int unsigned BRK_RESET   = 16 + CHUNK_RESET;
  localparam int unsigned INIT_WORDS  = 5;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_NULL = 2'd1,
    STATUS_OOM  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FF_RD,
    S_FF_CHK,
    S_GROW,
    S_GR_RD,
    S_GR_CHK,
    S_LV_RD,
    S_LV_CHK,
    S_FR_PREV,
    S_FR_NEXT,
    S_FR_CHK,
    S_WRITE,
    S_DONE
  } state_e;

  // Heap image after reset: prologue tags, one free chunk and the epilogue
  function automatic logic [WIDX_W-1:0] init_addr(input logic [2:0] i);
    logic [WIDX_W-1:0] a;
    case (i)
      3'd0:    a = WIDX_W'(1);
      3'd1:    a = WIDX_W'(2);
      3'd2:    a = WIDX_W'(3);
      3'd3:    a = WIDX_W'((16 + CHUNK_RESET - 8) / 4);
      default: a = WIDX_W'((16 + CHUNK_RESET - 4) / 4);
    endcase
    return a;
  endfunction

  function automatic logic [DATA_W-1:0] init_data(input logic [2:0] i);
    logic [DATA_W-1:0] d;
    case (i)
      3'd0, 3'd1: d = DATA_W'(9);
      3'd2, 3'd3: d = DATA_W'(CHUNK_RESET);
      default:    d = DATA_W'(1);
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ila_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ila_req_if / ila_rsp_if / ila_cfg_if
// Valid/ready channels of the heap allocator.
// ----------------------------------------------------------------------------
interface ila_req_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [ila_pkg::REQ_W-1:0]      request_size;
  logic [ila_pkg::BADDR_W-1:0]    block_address;
  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

interface ila_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ila_pkg::BADDR_W-1:0]    payload_address;
  logic [1:0]                     status;
  modport source (output valid, payload_address, status, input ready);
  modport sink   (input valid, payload_address, status, output ready);
endinterface

interface ila_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ila_pkg::CHUNK_W-1:0]    extend_chunk_bytes;
  modport source (output valid, extend_chunk_bytes, input ready);
  modport sink   (input valid, extend_chunk_bytes, output ready);
endinterface
`default_nettype wire

/* rtl/core/ila_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ila_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ila_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/implicit_list_heap_allocator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_core
// First-fit boundary-tag heap allocator over a single-port word memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one transaction per operation: mode 0 allocates
//   request_size bytes, mode 1 frees the block whose payload is at
//   block_address. rsp_if returns one transaction per request with the
//   payload address and a status (ok, zero-size, out of memory).
//   cfg_if writes extend_chunk_bytes; write it only while the block is idle.
// Operation: at most one heap memory access per cycle. An allocation walks
//   the block headers in first-fit order, reading each one; at the end of
//   the list it grows the break (new epilogue, then the tag below the old
//   break) unless the heap is full, then makes 2 or 4 writes to place the
//   block and hands the result off. A free walks the headers up to the freed
//   block, reads both neighbours' tags, merges them, makes 2 writes and hands
//   the result off. One operation is in flight at a time; the single memory
//   port and the length of the block list set the rate.
// Reset: the heap image (prologue, one free 256-byte chunk, epilogue) is
//   written word by word after reset, during which req_if.ready stays low.
// Stall: the result waits in an output register; the next request is taken
//   while it waits, but its own result holds until the receiver takes the
//   earlier one.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ila_req_if.sink    req_if,
  ila_rsp_if.source  rsp_if,
  ila_cfg_if.sink    cfg_if
);

  localparam int unsigned PW = ila_pkg::PTR_W;
  localparam int unsigned DW = ila_pkg::DATA_W;
  localparam int unsigned IW = ila_pkg::WIDX_W;
  localparam int unsigned XW = ila_pkg::EXT_W;

  ila_pkg::state_e state_q, state_d;

  logic [DW-1:0]                   brk_q, brk_d;
  logic [ila_pkg::CHUNK_W-1:0]     chunk_q;
  logic [PW-1:0]                   bp_q, bp_d;
  logic [PW-1:0]                   asize_q, asize_d;
  logic [DW-1:0]                   size_q, size_d;
  logic [DW-1:0]                   psize_q, psize_d;
  logic                            pused_q, pused_d;
  logic [ila_pkg::BADDR_W-1:0]     faddr_q, faddr_d;
  logic [IW-1:0]                   wa_q [4];
  logic [IW-1:0]                   wa_d [4];
  logic [DW-1:0]                   wd_q [4];
  logic [DW-1:0]                   wd_d [4];
  logic [2:0]                      wn_q, wn_d;
  logic [1:0]                      wi_q, wi_d;
  logic [2:0]                      init_q, init_d;
  logic [ila_pkg::BADDR_W-1:0]     res_addr_q, res_addr_d;
  ila_pkg::status_e                res_status_q, res_status_d;
  logic                            out_valid_q, out_valid_d;
  logic [ila_pkg::BADDR_W-1:0]     out_addr_q, out_addr_d;
  ila_pkg::status_e                out_status_q, out_status_d;

  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] mem_rdata;

  ila_ram #(
    .Width (DW),
    .Depth (ila_pkg::WORD_DEPTH)
  ) u_heap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign req_if.ready           = (state_q == ila_pkg::S_IDLE);
  assign cfg_if.ready           = 1'b1;
  assign rsp_if.valid           = out_valid_q;
  assign rsp_if.payload_address = out_addr_q;
  assign rsp_if.status          = out_status_q;

  always_comb begin
    logic [PW-1:0] hsize;
    logic          hused;
    logic [PW-1:0] cbp;
    logic [PW-1:0] csize;
    logic [PW-1:0] rest;
    logic          do_carve;
    logic [XW-1:0] ext;
    logic [XW-1:0] esize;
    logic [PW-1:0] nbp;
    logic [PW-1:0] nsz;
    logic [PW-1:0] t0;
    logic [PW-1:0] t1;
    logic [PW-1:0] t2;
    logic [PW-1:0] t3;

    state_d      = state_q;
    brk_d        = brk_q;
    bp_d         = bp_q;
    asize_d      = asize_q;
    size_d       = size_q;
    psize_d      = psize_q;
    pused_d      = pused_q;
    faddr_d      = faddr_q;
    wa_d         = wa_q;
    wd_d         = wd_q;
    wn_d         = wn_q;
    wi_d         = wi_q;
    init_d       = init_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;

    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;

    hsize    = {{(PW-DW){1'b0}}, mem_rdata[DW-1:3], 3'b000};
    hused    = mem_rdata[0];
    cbp      = bp_q;
    csize    = '0;
    rest     = '0;
    do_carve = 1'b0;
    ext      = '0;
    esize    = '0;
    nbp      = '0;
    nsz      = '0;
    t0       = '0;
    t1       = '0;
    t2       = '0;
    t3       = '0;

    if (rsp_if.valid && rsp_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ila_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = ila_pkg::init_addr(init_q);
        mem_wdata = ila_pkg::init_data(init_q);
        init_d    = init_q + 3'd1;
        if (init_q == 3'(ila_pkg::INIT_WORDS - 1)) begin
          state_d = ila_pkg::S_IDLE;
        end
      end

      ila_pkg::S_IDLE: begin
        if (req_if.valid) begin
          res_addr_d   = '0;
          res_status_d = ila_pkg::STATUS_OK;
          faddr_d      = req_if.block_address;
          if (req_if.mode == ila_pkg::MODE_FREE) begin
            bp_d    = PW'(ila_pkg::FIRST_BLOCK);
            state_d = ila_pkg::S_LV_RD;
          end else if (req_if.request_size == '0) begin
            res_status_d = ila_pkg::STATUS_NULL;
            state_d      = ila_pkg::S_DONE;
          end else begin
            if (req_if.request_size <= ila_pkg::REQ_W'(8)) begin
              asize_d = PW'(ila_pkg::MIN_BLOCK);
            end else begin
              asize_d = (PW'(req_if.request_size) + PW'(15)) & ~PW'(7);
            end
            bp_d    = PW'(ila_pkg::FIRST_BP);
            state_d = ila_pkg::S_FF_RD;
          end
        end
      end

      ila_pkg::S_FF_RD: begin
        if (bp_q >= PW'(brk_q)) begin
          state_d = ila_pkg::S_GROW;
        end else begin
          t0       = bp_q - PW'(4);
          mem_addr = t0[IW+1:2];
          state_d  = ila_pkg::S_FF_CHK;
        end
      end

      ila_pkg::S_FF_CHK: begin
        if (hsize == '0) begin
          state_d = ila_pkg::S_GROW;
        end else if (!hused && (asize_q <= hsize)) begin
          cbp      = bp_q;
          csize    = hsize;
          do_carve = 1'b1;
        end else begin
          bp_d    = bp_q + hsize;
          state_d = ila_pkg::S_FF_RD;
        end
      end

      ila_pkg::S_GROW: begin
        ext   = (XW'(asize_q) > XW'(chunk_q)) ? XW'(asize_q) : XW'(chunk_q);
        esize = (ext + XW'(7)) & ~XW'(7);
        if ((esize > XW'(ila_pkg::HEAP_BYTES)) ||
            ((XW'(brk_q) + esize) > XW'(ila_pkg::HEAP_BYTES))) begin
          res_status_d = ila_pkg::STATUS_OOM;
          state_d      = ila_pkg::S_DONE;
        end else begin
          // new epilogue just below the new break
          t0        = PW'(XW'(brk_q) + esize - XW'(4));
          mem_we    = 1'b1;
          mem_addr  = t0[IW+1:2];
          mem_wdata = DW'(1);
          bp_d      = PW'(brk_q);
          size_d    = DW'(esize);
          brk_d     = DW'(XW'(brk_q) + esize);
          state_d   = ila_pkg::S_GR_RD;
        end
      end

      ila_pkg::S_GR_RD: begin
        t0       = bp_q - PW'(8);
        mem_addr = t0[IW+1:2];
        state_d  = ila_pkg::S_GR_CHK;
      end

      ila_pkg::S_GR_CHK: begin
        // merge with a free tail; the tags are rewritten by the placement
        if (hused) begin
          cbp   = bp_q;
          csize = PW'(size_q);
        end else begin
          cbp   = bp_q - hsize;
          csize = PW'(size_q) + hsize;
        end
        do_carve = 1'b1;
      end

      ila_pkg::S_LV_RD: begin
        if ((bp_q < PW'(brk_q)) && (bp_q <= PW'(faddr_q))) begin
          t0       = bp_q - PW'(4);
          mem_addr = t0[IW+1:2];
          state_d  = ila_pkg::S_LV_CHK;
        end else begin
          state_d = ila_pkg::S_DONE;
        end
      end

      ila_pkg::S_LV_CHK: begin
        if (hsize == '0) begin
          state_d = ila_pkg::S_DONE;
        end else if (bp_q == PW'(faddr_q)) begin
          size_d  = DW'(hsize);
          state_d = hused ? ila_pkg::S_FR_PREV : ila_pkg::S_DONE;
        end else begin
          bp_d    = bp_q + hsize;
          state_d = ila_pkg::S_LV_RD;
        end
      end

      ila_pkg::S_FR_PREV: begin
        t0       = PW'(faddr_q) - PW'(8);
        mem_addr = t0[IW+1:2];
        state_d  = ila_pkg::S_FR_NEXT;
      end

      ila_pkg::S_FR_NEXT: begin
        psize_d  = DW'(hsize);
        pused_d  = hused;
        t0       = PW'(faddr_q) + PW'(size_q) - PW'(4);
        mem_addr = t0[IW+1:2];
        state_d  = ila_pkg::S_FR_CHK;
      end

      ila_pkg::S_FR_CHK: begin
        nbp = PW'(faddr_q);
        nsz = PW'(size_q);
        if (!hused) begin
          nsz = nsz + hsize;
        end
        if (!pused_q) begin
          nbp = nbp - PW'(psize_q);
          nsz = nsz + PW'(psize_q);
        end
        t0       = nbp - PW'(4);
        t1       = nbp + nsz - PW'(8);
        wa_d[0]  = t0[IW+1:2];
        wd_d[0]  = DW'(nsz);
        wa_d[1]  = t1[IW+1:2];
        wd_d[1]  = DW'(nsz);
        wn_d     = 3'd2;
        wi_d     = '0;
        state_d  = ila_pkg::S_WRITE;
      end

      ila_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = wa_q[wi_q];
        mem_wdata = wd_q[wi_q];
        wi_d      = wi_q + 2'd1;
        if ({1'b0, wi_q} == wn_q - 3'd1) begin
          state_d = ila_pkg::S_DONE;
        end
      end

      ila_pkg::S_DONE: begin
        if (!out_valid_q || rsp_if.ready) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = ila_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ila_pkg::S_IDLE;
      end
    endcase

    // place the block, splitting off a free remainder of a minimum block or more
    if (do_carve) begin
      rest = csize - asize_q;
      t0   = cbp - PW'(4);
      wi_d = '0;
      res_addr_d = cbp[ila_pkg::BADDR_W-1:0];
      if (rest >= PW'(ila_pkg::MIN_BLOCK)) begin
        t1      = cbp + asize_q - PW'(8);
        t2      = cbp + asize_q - PW'(4);
        t3      = cbp + csize - PW'(8);
        wa_d[0] = t0[IW+1:2];
        wd_d[0] = DW'(asize_q) | DW'(1);
        wa_d[1] = t1[IW+1:2];
        wd_d[1] = DW'(asize_q) | DW'(1);
        wa_d[2] = t2[IW+1:2];
        wd_d[2] = DW'(rest);
        wa_d[3] = t3[IW+1:2];
        wd_d[3] = DW'(rest);
        wn_d    = 3'd4;
      end else begin
        t1      = cbp + csize - PW'(8);
        wa_d[0] = t0[IW+1:2];
        wd_d[0] = DW'(csize) | DW'(1);
        wa_d[1] = t1[IW+1:2];
        wd_d[1] = DW'(csize) | DW'(1);
        wn_d    = 3'd2;
      end
      state_d = ila_pkg::S_WRITE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ila_pkg::S_INIT;
      init_q      <= '0;
      brk_q       <= DW'(ila_pkg::BRK_RESET);
      chunk_q     <= ila_pkg::CHUNK_W'(ila_pkg::CHUNK_RESET);
      out_valid_q <= 1'b0;
      wn_q        <= '0;
      wi_q        <= '0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
      wn_q        <= wn_d;
      wi_q        <= wi_d;
      if (cfg_if.valid) begin
        chunk_q <= cfg_if.extend_chunk_bytes;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q         <= bp_d;
    asize_q      <= asize_d;
    size_q       <= size_d;
    psize_q      <= psize_d;
    pused_q      <= pused_d;
    faddr_q      <= faddr_d;
    wa_q         <= wa_d;
    wd_q         <= wd_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

`ifndef NO_ASSERTIONS
  a_brk_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (brk_q[2:0] == 3'b000) && (XW'(brk_q) <= XW'(ila_pkg::HEAP_BYTES)))
    else $error("heap break misaligned or beyond the heap");

  a_brk_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && (state_q != ila_pkg::S_INIT)) |-> (brk_q >= $past(brk_q)))
    else $error("heap break moved down");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_if.valid && req_if.ready) |=> (state_q != ila_pkg::S_IDLE))
    else $error("accepted transaction left the controller idle");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ila_pkg::S_DONE))
    else $error("result raised outside the hand-off state");

  a_fail_null_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ila_pkg::STATUS_OK)) |-> (out_addr_q == '0))
    else $error("failed request carries a non-null address");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb_implicit_list_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// tb_implicit_list_heap_allocator_core
// Drives allocate and free transactions into the boundary-tag heap allocator.
// A local first-fit heap image predicts every response, and the monitor checks
// each one in order. The run covers several chunk settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_implicit_list_heap_allocator_core;

  localparam int unsigned WORDS       = ila_pkg::HEAP_BYTES / 4;
  localparam int unsigned DW          = ila_pkg::DATA_W;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct {
    ila_pkg::mode_e                  mode;
    logic [ila_pkg::REQ_W-1:0]       req_size;
    logic [ila_pkg::BADDR_W-1:0]     addr;
    bit                              pick_live;
  } heap_op_t;

  typedef struct {
    logic [ila_pkg::BADDR_W-1:0]     payload;
    ila_pkg::status_e                status;
  } heap_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ila_req_if req_bus ();
  ila_rsp_if rsp_bus ();
  ila_cfg_if cfg_bus ();

  implicit_list_heap_allocator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_bus),
    .rsp_if (rsp_bus),
    .cfg_if (cfg_bus)
  );

  always #5 clk_i = ~clk_i;

  heap_op_t    op_queue[$];
  heap_rsp_t   rsp_expected[$];
  int unsigned live_blocks[$];
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 16;
  int unsigned snk_idle_pct = 45;
  int unsigned cycles = 0;

  // Local copy of the heap and its registers
  logic [DW-1:0]     heap_img[WORDS];
  int unsigned       brk;
  int unsigned       chunk_bytes;

  function automatic int unsigned rd_word(int unsigned a);
    int unsigned i;
    i = a >> 2;
    return (i < WORDS) ? 32'(heap_img[i]) : 0;
  endfunction

  function automatic void wr_word(int unsigned a, int unsigned v);
    int unsigned i;
    i = a >> 2;
    if (i < WORDS) heap_img[i] = v[DW-1:0];
  endfunction

  function automatic int unsigned size_at(int unsigned a);
    return rd_word(a) & ~32'd7;
  endfunction

  function automatic int unsigned used_at(int unsigned a);
    return rd_word(a) & 32'd1;
  endfunction

  function automatic void put_tags(int unsigned bp, int unsigned sz, int unsigned u);
    wr_word(bp - 4, sz | u);
    wr_word(bp + sz - 8, sz | u);
  endfunction

  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned sz, pu, nbp, nu, pbp;
    sz  = size_at(bp - 4);
    pu  = used_at(bp - 8);
    nbp = bp + sz;
    nu  = used_at(nbp - 4);
    pbp = bp - size_at(bp - 8);
    if (pu && nu) return bp;
    if (pu) begin
      put_tags(bp, sz + size_at(nbp - 4), 0);
      return bp;
    end
    if (nu) begin
      put_tags(pbp, sz + size_at(pbp - 4), 0);
      return pbp;
    end
    put_tags(pbp, sz + size_at(pbp - 4) + size_at(nbp - 4), 0);
    return pbp;
  endfunction

  function automatic int unsigned grow_img(int unsigned bytes);
    int unsigned sz, bp;
    sz = (bytes + 7) & ~32'd7;
    bp = brk;
    if (sz > ila_pkg::HEAP_BYTES || bp > ila_pkg::HEAP_BYTES - sz) return 0;
    brk = bp + sz;
    put_tags(bp, sz, 0);
    wr_word(bp + sz - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic int unsigned scan_fit(int unsigned asz);
    int unsigned bp, s;
    bp = ila_pkg::FIRST_BP;
    while (bp < brk) begin
      s = size_at(bp - 4);
      if (s == 0) return 0;
      if (!used_at(bp - 4) && asz <= s) return bp;
      bp += s;
    end
    return 0;
  endfunction

  function automatic bit block_is_live(int unsigned a);
    int unsigned bp, s;
    bp = ila_pkg::FIRST_BP + 8;
    while (bp < brk && bp <= a) begin
      s = size_at(bp - 4);
      if (s == 0) return 1'b0;
      if (bp == a) return used_at(bp - 4) != 0;
      bp += s;
    end
    return 1'b0;
  endfunction

  function automatic void heap_reset();
    for (int unsigned i = 0; i < WORDS; i++) heap_img[i] = '0;
    chunk_bytes = ila_pkg::CHUNK_RESET;
    wr_word(4, 9);
    wr_word(8, 9);
    wr_word(12, 1);
    brk = 16;
    void'(grow_img(ila_pkg::CHUNK_RESET));
  endfunction

  // Apply one accepted operation to the heap image and queue its response
  function automatic void predict_heap_op(heap_op_t op);
    heap_rsp_t   r;
    int unsigned asz, bp, ext, csz, fa, rq;
    int          qi[$];
    r.payload = '0;
    r.status  = ila_pkg::STATUS_OK;
    fa = 32'(op.addr);
    rq = 32'(op.req_size);
    if (op.mode == ila_pkg::MODE_FREE) begin
      if (block_is_live(fa)) begin
        put_tags(fa, size_at(fa - 4), 0);
        void'(coalesce(fa));
        qi = live_blocks.find_first_index(x) with (x == fa);
        if (qi.size() > 0) live_blocks.delete(qi[0]);
      end
    end else if (rq == 0) begin
      r.status = ila_pkg::STATUS_NULL;
    end else begin
      asz = (rq <= 8) ? ila_pkg::MIN_BLOCK : 8 * ((rq + 15) / 8);
      bp  = scan_fit(asz);
      if (bp == 0) begin
        ext = (asz > chunk_bytes) ? asz : chunk_bytes;
        bp  = grow_img(ext);
      end
      if (bp == 0) begin
        r.status = ila_pkg::STATUS_OOM;
      end else begin
        csz = size_at(bp - 4);
        if (csz - asz >= ila_pkg::MIN_BLOCK) begin
          put_tags(bp, asz, 1);
          put_tags(bp + asz, csz - asz, 0);
        end else begin
          put_tags(bp, csz, 1);
        end
        r.payload = bp[ila_pkg::BADDR_W-1:0];
        live_blocks.push_back(bp);
      end
    end
    rsp_expected.push_back(r);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  // Request driver: predict on acceptance, then load the next transaction
  always @(posedge clk_i or negedge rst_ni) begin
    heap_op_t op;
    if (!rst_ni) begin
      req_bus.valid         <= 1'b0;
      req_bus.mode          <= ila_pkg::MODE_ALLOC;
      req_bus.request_size  <= '0;
      req_bus.block_address <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        op.mode      = ila_pkg::mode_e'(req_bus.mode);
        op.req_size  = req_bus.request_size;
        op.addr      = req_bus.block_address;
        op.pick_live = 1'b0;
        predict_heap_op(op);
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (op_queue.size() == 0 || $urandom_range(99) < src_idle_pct) begin
          req_bus.valid <= 1'b0;
        end else begin
          op = op_queue.pop_front();
          if (op.pick_live && live_blocks.size() > 0)
            op.addr = ila_pkg::BADDR_W'(
                live_blocks[$urandom_range(live_blocks.size() - 1)]);
          req_bus.mode          <= op.mode;
          req_bus.request_size  <= op.req_size;
          req_bus.block_address <= op.addr;
          req_bus.valid         <= 1'b1;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    heap_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (rsp_expected.size() == 0) begin
          report_mismatch("response with nothing outstanding");
        end else begin
          exp_rsp = rsp_expected.pop_front();
          if (rsp_bus.payload_address !== exp_rsp.payload)
            report_mismatch($sformatf("payload_address %0d, want %0d",
                                      rsp_bus.payload_address, exp_rsp.payload));
          if (rsp_bus.status !== exp_rsp.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      rsp_bus.status, exp_rsp.status));
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic heap_op_t mk_op(ila_pkg::mode_e m, int unsigned sz, int unsigned a);
    heap_op_t op;
    op.mode      = m;
    op.req_size  = sz[ila_pkg::REQ_W-1:0];
    op.addr      = a[ila_pkg::BADDR_W-1:0];
    op.pick_live = 1'b0;
    return op;
  endfunction

  function automatic heap_op_t random_op();
    heap_op_t    op;
    int unsigned roll, sroll;
    roll = $urandom_range(99);
    op   = mk_op(ila_pkg::MODE_ALLOC, 0, $urandom_range(65535));
    if (roll < 3) begin
      op.req_size = '0;
    end else if (roll < 55) begin
      sroll = $urandom_range(99);
      if (sroll < 70)      op.req_size = ila_pkg::REQ_W'($urandom_range(64, 1));
      else if (sroll < 90) op.req_size = ila_pkg::REQ_W'($urandom_range(512, 65));
      else if (sroll < 98) op.req_size = ila_pkg::REQ_W'($urandom_range(4096, 513));
      else                 op.req_size = ila_pkg::REQ_W'($urandom_range(65535, 1));
    end else if (roll < 92) begin
      op.mode      = ila_pkg::MODE_FREE;
      op.pick_live = 1'b1;
      op.req_size  = ila_pkg::REQ_W'($urandom_range(65535));
    end else begin
      // Bad free: random offset, often a stale or interior address
      op.mode     = ila_pkg::MODE_FREE;
      op.req_size = ila_pkg::REQ_W'($urandom_range(65535));
    end
    return op;
  endfunction

  // Sample at the falling edge so that the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (op_queue.size() != 0 || rsp_expected.size() != 0 || req_bus.valid);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_chunk(int unsigned v);
    @(posedge clk_i);
    cfg_bus.valid              <= 1'b1;
    cfg_bus.extend_chunk_bytes <= v[ila_pkg::CHUNK_W-1:0];
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    chunk_bytes = v & 32'h1FFFF;
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) op_queue.push_back(random_op());
  endtask

  initial begin
    cfg_bus.valid              = 1'b0;
    cfg_bus.extend_chunk_bytes = '0;
    heap_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_chunk(ila_pkg::CHUNK_RESET);
    // Four neighbouring blocks, then frees that merge with neither, the next or both neighbours
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 0, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 1, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 8, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 9, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 16, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 32));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 16));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 72));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 48));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 48));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, ila_pkg::FIRST_BP));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 65535, 65535));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 65535, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 300, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 20));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 40000, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 30000, 0));
    op_queue.push_back(mk_op(ila_pkg::MODE_FREE, 0, 16));
    op_queue.push_back(mk_op(ila_pkg::MODE_ALLOC, 24, 0));
    wait_idle();

    write_chunk(8);
    run_random(225);
    // Hold the sender until the block has drained
    wait_idle();
    run_random(225);
    wait_idle();

    write_chunk(65536);
    src_idle_pct = 45;
    snk_idle_pct = 16;
    run_random(450);
    wait_idle();

    write_chunk(1001);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(450);
    wait_idle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ila_pkg.sv
rtl/core/ila_if.sv
rtl/core/ila_ram.sv
rtl/core/implicit_list_heap_allocator_core.sv
tb/sv/tb_implicit_list_heap_allocator_core.sv
